// ===== rtl/core/mau_pkg.sv =====
// Shared widths, operation codes and divider handshake types of the modular arithmetic unit.
`default_nettype none
package mau_pkg;

  localparam int unsigned VW  = 16;
  localparam int unsigned PW  = 2 * VW;
  localparam int unsigned SW  = VW + 2;
  localparam int unsigned CMW = 3;

  localparam logic [CMW-1:0] CMD_ADD = 3'd0;
  localparam logic [CMW-1:0] CMD_SUB = 3'd1;
  localparam logic [CMW-1:0] CMD_MUL = 3'd2;
  localparam logic [CMW-1:0] CMD_INV = 3'd3;
  localparam logic [CMW-1:0] CMD_DIV = 3'd4;

  localparam logic [VW-1:0] MODULUS_RESET = 16'd65521;

  typedef struct packed {
    logic          start;
    logic          wide;
    logic [PW-1:0] dividend;
    logic [VW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [VW-1:0] quot;
    logic [VW-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/mau_if.sv =====
// Handshake interfaces for the operation, result and modulus write channels.
`default_nettype none
interface mau_in_if;
  import mau_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMW-1:0]      cmd;
  logic [VW-1:0]       operand_a;
  logic [VW-1:0]       operand_b;
  modport source (output valid, output cmd, output operand_a, output operand_b, input ready);
  modport sink (input valid, input cmd, input operand_a, input operand_b, output ready);
endinterface

interface mau_out_if;
  import mau_pkg::*;
  logic          valid;
  logic          ready;
  logic [VW-1:0] result;
  modport source (output valid, output result, input ready);
  modport sink (input valid, input result, output ready);
endinterface

interface mau_cfg_if;
  import mau_pkg::*;
  logic          valid;
  logic          ready;
  logic [VW-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mau_div.sv =====
// Restoring radix-2 divider shared by all operand and product reductions and Euclid steps.
`default_nettype none
module mau_div (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  mau_pkg::div_req_t req_i,
  output mau_pkg::div_rsp_t rsp_o
);
  import mau_pkg::*;

  localparam int unsigned CW = $clog2(PW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [PW-1:0] shf_q, shf_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [VW-1:0] dvs_q, dvs_d;

  logic [VW:0]   trial;
  logic          ge;

  assign trial = {rem_q, shf_q[PW-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    shf_d  = shf_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      if (req_i.wide) begin
        shf_d = req_i.dividend;
        cnt_d = CW'(PW);
      end else begin
        shf_d = {req_i.dividend[VW-1:0], {VW{1'b0}}};
        cnt_d = CW'(VW);
      end
    end else if (busy_q) begin
      rem_d = ge ? VW'(trial - {1'b0, dvs_q}) : trial[VW-1:0];
      shf_d = {shf_q[PW-2:0], ge};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shf_q <= shf_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = shf_q[VW-1:0];
  assign rsp_o.rem  = rem_q;

endmodule
`default_nettype wire

// ===== rtl/core/modular_arith_unit.sv =====
// Top level of the modular arithmetic unit: sequencer around a shared divider.
// The block computes add, subtract, multiply, inverse and divide modulo the
// prime held in the modulus register. A word on cfg_i writes that register;
// cfg_i is always ready, and writes are meant for times when the block is idle.
// A word on in_i carries cmd, operand_a and operand_b; in_i is ready only while
// no operation is in flight. Each operation yields one word on out_o.
// Each operand reduction, product reduction and Euclid step is one pass of the
// shared divider, on a 16-bit dividend or, for a product, a full 32-bit one;
// add and subtract reduce their sum with one conditional subtraction.
// Inverse runs one divider pass per Euclid step, with up to about 23 steps;
// divide adds one product reduction to that.
// A zero modulus or an unused cmd gives result 0.
// The result register frees the datapath; when out_o stalls with a result
// still held, the next operation waits at its end until that word is taken.
// Reset empties the result register, idles the sequencer and loads 65521 into
// the modulus register.
`default_nettype none
module modular_arith_unit (
  input  wire        clk_i,
  input  wire        rst_ni,
  mau_cfg_if.sink    cfg_i,
  mau_in_if.sink     in_i,
  mau_out_if.source  out_o
);
  import mau_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RA   = 4'd1;
  localparam logic [3:0] S_RAW  = 4'd2;
  localparam logic [3:0] S_RB   = 4'd3;
  localparam logic [3:0] S_RBW  = 4'd4;
  localparam logic [3:0] S_EXEC = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_RED  = 4'd7;
  localparam logic [3:0] S_REDW = 4'd8;
  localparam logic [3:0] S_EU   = 4'd9;
  localparam logic [3:0] S_EUW  = 4'd10;
  localparam logic [3:0] S_FIX  = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  localparam int unsigned MXW = VW + 1;
  localparam int unsigned PRW = MXW + SW;

  logic [3:0]            state_q, state_d;
  logic [VW-1:0]         mod_q, mod_d;
  logic                  ov_q, ov_d;
  logic [VW-1:0]         out_q, out_d;
  logic [CMW-1:0]        cmd_q, cmd_d;
  logic [VW-1:0]         araw_q, araw_d;
  logic [VW-1:0]         braw_q, braw_d;
  logic [VW-1:0]         a_q, a_d;
  logic [VW-1:0]         b_q, b_d;
  logic [VW-1:0]         res_q, res_d;
  logic [PW-1:0]         prod_q, prod_d;
  logic [VW-1:0]         ea_q, ea_d;
  logic [VW-1:0]         eb_q, eb_d;
  logic signed [SW-1:0]  s0_q, s0_d;
  logic signed [SW-1:0]  s1_q, s1_d;

  div_req_t              dreq;
  div_rsp_t              drsp;

  logic signed [MXW-1:0] mx;
  logic signed [SW-1:0]  my;
  logic signed [PRW-1:0] mp;
  logic signed [PRW-1:0] s_upd;
  logic signed [SW:0]    fx0, fx1, fpw;
  logic [VW:0]           sum_add, sum_sub;

  mau_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  assign mx    = (state_q == S_MUL) ? $signed({1'b0, a_q}) : $signed({1'b0, drsp.quot});
  assign my    = (state_q == S_MUL) ? $signed({2'b00, b_q}) : s0_q;
  assign mp    = mx * my;
  assign s_upd = PRW'(s1_q) - mp;

  assign fpw = $signed({3'b000, mod_q});
  assign fx0 = (s0_q < 0) ? (SW + 1)'(s0_q) + fpw : (SW + 1)'(s0_q);
  assign fx1 = (fx0 >= fpw) ? fx0 - fpw : fx0;

  assign sum_add = {1'b0, a_q} + {1'b0, b_q};
  assign sum_sub = {1'b0, a_q} + {1'b0, mod_q} - {1'b0, b_q};

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid  = ov_q;
  assign out_o.result = out_q;

  always_comb begin
    state_d = state_q;
    mod_d   = mod_q;
    ov_d    = ov_q & ~out_o.ready;
    out_d   = out_q;
    cmd_d   = cmd_q;
    araw_d  = araw_q;
    braw_d  = braw_q;
    a_d     = a_q;
    b_d     = b_q;
    res_d   = res_q;
    prod_d  = prod_q;
    ea_d    = ea_q;
    eb_d    = eb_q;
    s0_d    = s0_q;
    s1_d    = s1_q;
    dreq.start    = 1'b0;
    dreq.wide     = 1'b0;
    dreq.dividend = {{VW{1'b0}}, araw_q};
    dreq.divisor  = mod_q;

    if (cfg_i.valid) begin
      mod_d = cfg_i.data;
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          cmd_d  = in_i.cmd;
          araw_d = in_i.operand_a;
          braw_d = in_i.operand_b;
          if ((mod_q == '0) || (in_i.cmd > CMD_DIV)) begin
            res_d   = '0;
            state_d = S_OUT;
          end else begin
            state_d = S_RA;
          end
        end
      end
      S_RA: begin
        dreq.start = 1'b1;
        state_d    = S_RAW;
      end
      S_RAW: begin
        if (drsp.done) begin
          a_d     = drsp.rem;
          state_d = S_RB;
        end
      end
      S_RB: begin
        dreq.start    = 1'b1;
        dreq.dividend = {{VW{1'b0}}, braw_q};
        state_d       = S_RBW;
      end
      S_RBW: begin
        if (drsp.done) begin
          b_d     = drsp.rem;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cmd_q)
          CMD_ADD: begin
            res_d   = (sum_add >= {1'b0, mod_q}) ? VW'(sum_add - {1'b0, mod_q})
                                                 : sum_add[VW-1:0];
            state_d = S_OUT;
          end
          CMD_SUB: begin
            res_d   = (sum_sub >= {1'b0, mod_q}) ? VW'(sum_sub - {1'b0, mod_q})
                                                 : sum_sub[VW-1:0];
            state_d = S_OUT;
          end
          CMD_MUL: begin
            state_d = S_MUL;
          end
          CMD_INV: begin
            ea_d    = a_q;
            eb_d    = mod_q;
            s0_d    = '0;
            s1_d    = SW'(1);
            state_d = S_EU;
          end
          CMD_DIV: begin
            ea_d    = b_q;
            eb_d    = mod_q;
            s0_d    = '0;
            s1_d    = SW'(1);
            state_d = S_EU;
          end
          default: begin
            res_d   = '0;
            state_d = S_OUT;
          end
        endcase
      end
      S_MUL: begin
        prod_d  = mp[PW-1:0];
        state_d = S_RED;
      end
      S_RED: begin
        dreq.start    = 1'b1;
        dreq.wide     = 1'b1;
        dreq.dividend = prod_q;
        state_d       = S_REDW;
      end
      S_REDW: begin
        if (drsp.done) begin
          res_d   = drsp.rem;
          state_d = S_OUT;
        end
      end
      S_EU: begin
        dreq.start    = 1'b1;
        dreq.dividend = {{VW{1'b0}}, ea_q};
        dreq.divisor  = eb_q;
        state_d       = S_EUW;
      end
      S_EUW: begin
        if (drsp.done) begin
          if (drsp.rem == '0) begin
            state_d = S_FIX;
          end else begin
            ea_d    = eb_q;
            eb_d    = drsp.rem;
            s0_d    = s_upd[SW-1:0];
            s1_d    = s0_q;
            state_d = S_EU;
          end
        end
      end
      S_FIX: begin
        if (cmd_q == CMD_INV) begin
          res_d   = fx1[VW-1:0];
          state_d = S_OUT;
        end else begin
          b_d     = fx1[VW-1:0];
          state_d = S_MUL;
        end
      end
      S_OUT: begin
        if (!ov_q || out_o.ready) begin
          ov_d    = 1'b1;
          out_d   = res_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mod_q   <= MODULUS_RESET;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      mod_q   <= mod_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    cmd_q  <= cmd_d;
    araw_q <= araw_d;
    braw_q <= braw_d;
    a_q    <= a_d;
    b_q    <= b_d;
    res_q  <= res_d;
    prod_q <= prod_d;
    ea_q   <= ea_d;
    eb_q   <= eb_d;
    s0_q   <= s0_d;
    s1_q   <= s1_d;
  end

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for modular_arith_unit: directed and random words checked against a predictor.
`timescale 1ns / 1ps
module tb_top;
  import mau_pkg::*;

  localparam logic [CMW-1:0] CMD_UNUSED5 = 3'd5;
  localparam logic [CMW-1:0] CMD_UNUSED6 = 3'd6;
  localparam logic [CMW-1:0] CMD_UNUSED7 = 3'd7;

  localparam int CLK_HALF         = 5;
  localparam int RESET_CYCLES     = 12;
  localparam int LONG_HOLD_CYCLES = 800;
  localparam int SETTLE_CYCLES    = 600;
  localparam int N_DIRECTED       = 25;
  localparam int N_PHASES         = 11;
  localparam int DRAIN_PHASE      = 7;
  localparam int DRAIN_ITEM       = 60;

  typedef struct packed {
    logic [VW-1:0]  modulus;
    logic [CMW-1:0] cmd;
    logic [VW-1:0]  a;
    logic [VW-1:0]  b;
    logic           known;
    logic [VW-1:0]  res;
  } stim_row_t;

  typedef struct packed {
    logic [VW-1:0]  modulus;
    logic [CMW-1:0] cmd;
    logic [VW-1:0]  a;
    logic [VW-1:0]  b;
    logic [VW-1:0]  res;
  } residue_t;

  logic clk_i;
  logic rst_ni;

  mau_cfg_if cfg_bus ();
  mau_in_if  op_bus ();
  mau_out_if res_bus ();

  modular_arith_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (op_bus),
    .out_o  (res_bus)
  );

  residue_t      pending_residues[$];
  logic [VW-1:0] cur_modulus;
  int            mismatch_count;
  bit            long_hold_req;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{16'd65521, CMD_ADD,     16'd0,     16'd0,     1'b1, 16'd0},
    '{16'd65521, CMD_ADD,     16'd65535, 16'd65535, 1'b1, 16'd28},
    '{16'd65521, CMD_SUB,     16'd0,     16'd1,     1'b1, 16'd65520},
    '{16'd65521, CMD_SUB,     16'd65535, 16'd65535, 1'b1, 16'd0},
    '{16'd65521, CMD_MUL,     16'd65520, 16'd65520, 1'b1, 16'd1},
    '{16'd65521, CMD_MUL,     16'd65535, 16'd65535, 1'b1, 16'd196},
    '{16'd65521, CMD_INV,     16'd1,     16'd65535, 1'b1, 16'd1},
    '{16'd65521, CMD_INV,     16'd0,     16'd0,     1'b1, 16'd0},
    '{16'd65521, CMD_INV,     16'd65521, 16'd7,     1'b1, 16'd0},
    '{16'd65521, CMD_INV,     16'd65520, 16'd0,     1'b1, 16'd65520},
    '{16'd65521, CMD_INV,     16'd12345, 16'd0,     1'b0, 16'd0},
    '{16'd65521, CMD_DIV,     16'd1,     16'd2,     1'b1, 16'd32761},
    '{16'd65521, CMD_DIV,     16'd7,     16'd0,     1'b1, 16'd0},
    '{16'd65521, CMD_DIV,     16'd54321, 16'd65534, 1'b0, 16'd0},
    '{16'd65521, CMD_UNUSED5, 16'd65535, 16'd65535, 1'b1, 16'd0},
    '{16'd65521, CMD_UNUSED6, 16'd1,     16'd1,     1'b1, 16'd0},
    '{16'd65521, CMD_UNUSED7, 16'd65535, 16'd0,     1'b1, 16'd0},
    '{16'd65535, CMD_INV,     16'd3,     16'd0,     1'b0, 16'd0},
    '{16'd65535, CMD_DIV,     16'd10,    16'd6,     1'b0, 16'd0},
    '{16'd65535, CMD_MUL,     16'd65534, 16'd65534, 1'b1, 16'd1},
    '{16'd2,     CMD_ADD,     16'd1,     16'd1,     1'b1, 16'd0},
    '{16'd2,     CMD_INV,     16'd65535, 16'd0,     1'b1, 16'd1},
    '{16'd1,     CMD_MUL,     16'd65535, 16'd65535, 1'b1, 16'd0},
    '{16'd0,     CMD_ADD,     16'd65535, 16'd65535, 1'b1, 16'd0},
    '{16'd0,     CMD_INV,     16'd5,     16'd0,     1'b1, 16'd0}
  };

  logic [VW-1:0] phase_modulus [N_PHASES] = '{
    16'd65521, 16'd2, 16'd3, 16'd251, 16'd65535, 16'd1, 16'd0,
    16'd32749, 16'd4096, 16'd0, 16'd65521
  };
  int phase_items [N_PHASES] = '{200, 60, 60, 150, 150, 25, 25, 200, 100, 130, 150};

  function automatic longint euclid_inverse(longint x, longint p);
    longint u, v, rem, q, coef_cur, coef_prev, t;
    u = x;
    v = p;
    coef_cur = 0;
    coef_prev = 1;
    rem = u % v;
    while (rem != 0) begin
      q = u / v;
      u = v;
      v = rem;
      t = coef_cur;
      coef_cur = coef_prev - q * coef_cur;
      coef_prev = t;
      rem = u % v;
    end
    t = coef_cur % p;
    if (t < 0) begin
      t += p;
    end
    return t;
  endfunction

  function automatic logic [VW-1:0] mod_result(logic [CMW-1:0] op, logic [VW-1:0] a_in,
                                               logic [VW-1:0] b_in, logic [VW-1:0] p_in);
    longint p, a, b, r;
    p = longint'(p_in);
    r = 0;
    if (p != 0) begin
      a = longint'(a_in) % p;
      b = longint'(b_in) % p;
      case (op)
        CMD_ADD: r = (a + b) % p;
        CMD_SUB: r = (a + p - b) % p;
        CMD_MUL: r = (a * b) % p;
        CMD_INV: r = euclid_inverse(a, p);
        CMD_DIV: r = (a * euclid_inverse(b, p)) % p;
        default: r = 0;
      endcase
    end
    return r[VW-1:0];
  endfunction

  function automatic logic [VW-1:0] pick_operand(logic [VW-1:0] p);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      return VW'($urandom_range(0, 65535));
    end else if (sel < 8) begin
      return VW'($urandom_range(0, 15));
    end
    case ($urandom_range(0, 4))
      0: return '0;
      1: return VW'(1);
      2: return p - VW'(1);
      3: return p;
      default: return '1;
    endcase
  endfunction

  function automatic logic [CMW-1:0] pick_cmd();
    if ($urandom_range(0, 19) == 0) begin
      return CMW'($urandom_range(CMD_UNUSED5, CMD_UNUSED7));
    end
    return CMW'($urandom_range(CMD_ADD, CMD_DIV));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic send_word(input logic [CMW-1:0] op, input logic [VW-1:0] a,
                           input logic [VW-1:0] b, input bit known, input logic [VW-1:0] typed);
    residue_t e;
    @(negedge clk_i);
    op_bus.valid = 1'b1;
    op_bus.cmd = op;
    op_bus.operand_a = a;
    op_bus.operand_b = b;
    do @(posedge clk_i); while (!op_bus.ready);
    e.modulus = cur_modulus;
    e.cmd = op;
    e.a = a;
    e.b = b;
    e.res = known ? typed : mod_result(op, a, b, cur_modulus);
    pending_residues.push_back(e);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    op_bus.valid = 1'b0;
    while (pending_residues.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_modulus(input logic [VW-1:0] value);
    wait_drained();
    @(negedge clk_i);
    cfg_bus.valid = 1'b1;
    cfg_bus.data = value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cur_modulus = value;
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  initial begin
    #30_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin : result_receiver
    int seg_left, stall_left, hold_left;
    bit quiet;
    seg_left = 0;
    stall_left = 0;
    hold_left = 0;
    quiet = 1'b0;
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_bus.ready = 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(50, 400);
          quiet = ($urandom_range(0, 2) == 0);
        end
        seg_left--;
        if (stall_left > 0) begin
          stall_left--;
          res_bus.ready = 1'b0;
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
          stall_left = $urandom_range(0, 10);
          res_bus.ready = 1'b0;
        end else begin
          res_bus.ready = 1'b1;
        end
      end
    end
  end

  initial begin : result_check
    residue_t e;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_bus.valid && res_bus.ready) begin
        if (pending_residues.size() == 0) begin
          report_mismatch($sformatf("result word %0d with nothing expected", res_bus.result));
        end else begin
          e = pending_residues.pop_front();
          if (res_bus.result !== e.res) begin
            report_mismatch($sformatf("p=%0d cmd=%0d a=%0d b=%0d: result %0d, expected %0d",
                                      e.modulus, e.cmd, e.a, e.b, res_bus.result, e.res));
          end
        end
      end
    end
  end

  initial begin : stimulus
    int burst_left, gap;
    logic [CMW-1:0] op;
    mismatch_count = 0;
    long_hold_req = 1'b0;
    cur_modulus = MODULUS_RESET;
    burst_left = 0;
    rst_ni = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data = '0;
    op_bus.valid = 1'b0;
    op_bus.cmd = CMD_ADD;
    op_bus.operand_a = '0;
    op_bus.operand_b = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].modulus != cur_modulus) begin
        write_modulus(directed_rows[i].modulus);
      end
      send_word(directed_rows[i].cmd, directed_rows[i].a, directed_rows[i].b,
                directed_rows[i].known, directed_rows[i].res);
    end

    phase_modulus[9] = VW'($urandom_range(2, 65535));
    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_modulus(phase_modulus[ph]);
      if (ph == 0) begin
        long_hold_req = 1'b1;
      end
      for (int i = 0; i < phase_items[ph]; i++) begin
        if (ph == DRAIN_PHASE && i == DRAIN_ITEM) begin
          wait_drained();
        end
        if (burst_left == 0) begin
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          if (gap > 0) begin
            @(negedge clk_i);
            op_bus.valid = 1'b0;
            repeat (gap - 1) @(negedge clk_i);
          end
          burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        op = pick_cmd();
        send_word(op, pick_operand(cur_modulus), pick_operand(cur_modulus), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== modular_arith_unit.f =====
rtl/core/mau_pkg.sv
rtl/core/mau_if.sv
rtl/core/mau_div.sv
rtl/core/modular_arith_unit.sv
test/tb_top.sv
